### rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared sizes, status codes and the memory port type of the allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAP_BLOCKS      = 128;
    localparam int MAX_FILE_BLOCKS = 64;
    localparam int BLOCK_BYTES     = 512;

    localparam int MAP_W    = (MAP_BLOCKS > 1) ? $clog2(MAP_BLOCKS) : 1;
    localparam int CNT_W    = $clog2(MAX_FILE_BLOCKS + 1);
    localparam int BB_SHIFT = $clog2(BLOCK_BYTES);
    localparam int SIZE_W   = 16;
    localparam int IDX_W    = 7;
    localparam int LINK_W   = 8;

    localparam logic [LINK_W-1:0] END_OF_CHAIN = LINK_W'(128);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_TOO_MANY = 2'd2,
        ST_RAN_OUT  = 2'd3
    } status_t;

    // One write port and one read port of the free map.
    typedef struct packed {
        logic             we;
        logic [MAP_W-1:0] waddr;
        logic             wdata;
        logic [MAP_W-1:0] raddr;
    } map_cmd_t;

    // Block number as carried in the 7-bit index field.
    function automatic logic [IDX_W-1:0] to_index(input logic [MAP_W-1:0] a);
        logic [MAP_W+LINK_W-1:0] t;
        t = {{LINK_W{1'b0}}, a};
        return t[IDX_W-1:0];
    endfunction

    // Block number as carried in the 8-bit link field.
    function automatic logic [LINK_W-1:0] to_link(input logic [MAP_W-1:0] a);
        logic [MAP_W+LINK_W-1:0] t;
        t = {{LINK_W{1'b0}}, a};
        return t[LINK_W-1:0];
    endfunction

endpackage

### rtl/core/bba_free_map.sv
// ----------------------------------------------------------------------------
// Free map memory
// One bit per disk block, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bba_free_map (
    input  logic              clk,
    input  bba_pkg::map_cmd_t cmd,
    output logic              rd_data
);

    logic mem [bba_pkg::MAP_BLOCKS];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
        rd_data_reg <= mem[cmd.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Keeps a free-block bitmap and hands out linked block chains for files.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                          Handshake
//  --------  -----------------------------------------------  ---------------------
//  request   req_type, block_addr, free_flag, file_size       start & !busy
//  result    block_index, chain_next, has_block, last, status  result_valid, 1 cycle
//
// A load request writes one map bit and is acknowledged on the next cycle;
// busy stays low, so loads can follow back to back. An allocate request that
// passes the size checks scans the map one block per cycle through the single
// read port of the free map; busy stays high until the allocate has finished.
// After reset the block runs a clearing pass over every map address that
// marks every block used; busy is high during that pass.
// Results are shown for exactly one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [6:0]  block_addr,
    input  logic        free_flag,
    input  logic [15:0] file_size,
    output logic        result_valid,
    output logic [6:0]  block_index,
    output logic [7:0]  chain_next,
    output logic        has_block,
    output logic        last,
    output logic [1:0]  status
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FAIL
    } state_t;

    localparam logic [bba_pkg::MAP_W-1:0] LAST_ADDR =
        bba_pkg::MAP_W'(bba_pkg::MAP_BLOCKS - 1);

    state_t                         state_reg, state_next;
    logic [bba_pkg::MAP_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [bba_pkg::MAP_W-1:0]      scan_addr_reg, scan_addr_next;
    logic [bba_pkg::MAP_W-1:0]      pend_addr_reg, pend_addr_next;
    logic                           pend_reg, pend_next;
    logic                           issue_done_reg, issue_done_next;
    logic [bba_pkg::CNT_W-1:0]      need_reg, need_next;
    logic [bba_pkg::CNT_W-1:0]      taken_reg, taken_next;
    logic [bba_pkg::LINK_W-1:0]     head_reg, head_next;

    logic                           res_valid_reg, res_valid_next;
    logic [bba_pkg::IDX_W-1:0]      res_index_reg, res_index_next;
    logic [bba_pkg::LINK_W-1:0]     res_link_reg, res_link_next;
    logic                           res_has_reg, res_has_next;
    logic                           res_last_reg, res_last_next;
    bba_pkg::status_t               res_status_reg, res_status_next;

    bba_pkg::map_cmd_t              map_cmd;
    logic                           map_rd;

    // Block count of the file: ceil(size / BLOCK_BYTES) by shifting.
    logic [bba_pkg::SIZE_W:0]       size_sum;
    logic [bba_pkg::SIZE_W:0]       need_full;
    // Load address widened so it can be checked against the map size.
    logic [bba_pkg::MAP_W+7:0]      load_addr_ext;
    logic                           load_in_range;
    logic                           hit;
    logic                           hit_done;

    assign size_sum  = {1'b0, file_size}
                     + (bba_pkg::SIZE_W+1)'(bba_pkg::BLOCK_BYTES - 1);
    assign need_full = size_sum >> bba_pkg::BB_SHIFT;

    assign load_addr_ext = {{(bba_pkg::MAP_W+1){1'b0}}, block_addr};
    assign load_in_range = (load_addr_ext < bba_pkg::MAP_BLOCKS);

    // A block read on the previous cycle came back free.
    assign hit      = pend_reg && map_rd;
    assign hit_done = hit && ((taken_reg + 1'b1) == need_reg);

    bba_free_map u_map (
        .clk     (clk),
        .cmd     (map_cmd),
        .rd_data (map_rd)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        scan_addr_next  = scan_addr_reg;
        pend_addr_next  = pend_addr_reg;
        pend_next       = pend_reg;
        issue_done_next = issue_done_reg;
        need_next       = need_reg;
        taken_next      = taken_reg;
        head_next       = head_reg;

        res_valid_next  = 1'b0;
        res_index_next  = '0;
        res_link_next   = bba_pkg::END_OF_CHAIN;
        res_has_next    = 1'b0;
        res_last_next   = 1'b1;
        res_status_next = bba_pkg::ST_OK;

        map_cmd.we    = 1'b0;
        map_cmd.waddr = clr_addr_reg;
        map_cmd.wdata = 1'b0;
        map_cmd.raddr = scan_addr_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // Every block starts out used.
                map_cmd.we    = 1'b1;
                map_cmd.waddr = clr_addr_reg;
                map_cmd.wdata = 1'b0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    res_valid_next = 1'b1;
                    if (!req_type)
                    begin
                        // Load: an address beyond the map is dropped but
                        // still acknowledged.
                        map_cmd.we    = load_in_range;
                        map_cmd.waddr = load_addr_ext[bba_pkg::MAP_W-1:0];
                        map_cmd.wdata = free_flag;
                    end
                    else
                    begin
                        head_next = bba_pkg::END_OF_CHAIN;
                        if (file_size == '0)
                        begin
                            res_status_next = bba_pkg::ST_ZERO;
                        end
                        else if (need_full > (bba_pkg::SIZE_W+1)'(bba_pkg::MAX_FILE_BLOCKS))
                        begin
                            res_status_next = bba_pkg::ST_TOO_MANY;
                        end
                        else
                        begin
                            res_valid_next  = 1'b0;
                            need_next       = need_full[bba_pkg::CNT_W-1:0];
                            taken_next      = '0;
                            scan_addr_next  = '0;
                            pend_next       = 1'b0;
                            issue_done_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next read; its data is checked in the next cycle.
                if (!issue_done_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = scan_addr_reg;
                    if (scan_addr_reg == LAST_ADDR)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // Take a free block: clear its bit and link it to the head.
                // The write goes to an address behind every read in flight.
                if (hit)
                begin
                    map_cmd.we      = 1'b1;
                    map_cmd.waddr   = pend_addr_reg;
                    map_cmd.wdata   = 1'b0;
                    res_valid_next  = 1'b1;
                    res_index_next  = bba_pkg::to_index(pend_addr_reg);
                    res_link_next   = head_reg;
                    res_has_next    = 1'b1;
                    res_last_next   = hit_done;
                    head_next       = bba_pkg::to_link(pend_addr_reg);
                    taken_next      = taken_reg + 1'b1;
                end

                if (hit_done)
                begin
                    state_next = S_IDLE;
                end
                else if (pend_reg && (pend_addr_reg == LAST_ADDR))
                begin
                    state_next = S_FAIL;
                end
            end

            S_FAIL:
            begin
                // The map ran out; blocks already taken stay taken.
                res_valid_next  = 1'b1;
                res_status_next = bba_pkg::ST_RAN_OUT;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            scan_addr_reg  <= '0;
            pend_addr_reg  <= '0;
            pend_reg       <= 1'b0;
            issue_done_reg <= 1'b0;
            need_reg       <= '0;
            taken_reg      <= '0;
            head_reg       <= bba_pkg::END_OF_CHAIN;
            res_valid_reg  <= 1'b0;
            res_index_reg  <= '0;
            res_link_reg   <= bba_pkg::END_OF_CHAIN;
            res_has_reg    <= 1'b0;
            res_last_reg   <= 1'b0;
            res_status_reg <= bba_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            scan_addr_reg  <= scan_addr_next;
            pend_addr_reg  <= pend_addr_next;
            pend_reg       <= pend_next;
            issue_done_reg <= issue_done_next;
            need_reg       <= need_next;
            taken_reg      <= taken_next;
            head_reg       <= head_next;
            res_valid_reg  <= res_valid_next;
            res_index_reg  <= res_index_next;
            res_link_reg   <= res_link_next;
            res_has_reg    <= res_has_next;
            res_last_reg   <= res_last_next;
            res_status_reg <= res_status_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign block_index  = res_index_reg;
    assign chain_next   = res_link_reg;
    assign has_block    = res_has_reg;
    assign last         = res_last_reg;
    assign status       = res_status_reg;

endmodule

### bench/bitmap_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives load and allocate requests through the start/busy handshake, mirrors
// the free map in a behavioral predictor and checks every result strobe
// field by field against the grants that the predictor expects.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_tb;

    // Request kinds carried on req_type.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // The slowest correct run is about 210 requests, each one holding busy for
    // at most one full map scan behind a random sender gap, plus the clearing
    // pass after reset. The limit lies far above that.
    localparam int CYCLE_LIMIT  = 400000;
    // An allocate can scan the whole map, so the drain after the last expected
    // result covers one full scan with margin.
    localparam int DRAIN_CYCLES = bba_pkg::MAP_BLOCKS + 64;
    // Least number of requests in the whole run, directed part included.
    localparam int TOTAL_ITEMS  = 210;
    // Printing stops here so that a broken block cannot flood the log.
    localparam int PRINT_LIMIT  = 100;

    typedef struct {
        logic        req_type;
        logic [6:0]  block_addr;
        logic        free_flag;
        logic [15:0] file_size;
    } request_t;

    typedef struct {
        logic [6:0]       block_index;
        logic [7:0]       chain_next;
        logic             has_block;
        logic             last;
        bba_pkg::status_t status;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [6:0]  block_addr;
    logic        free_flag;
    logic [15:0] file_size;
    logic        result_valid;
    logic [6:0]  block_index;
    logic [7:0]  chain_next;
    logic        has_block;
    logic        last;
    logic [1:0]  status;

    // Requests waiting for the driver, filled by the stimulus block.
    request_t request_queue[$];
    // Results the predictor has worked out and the block has not yet shown.
    grant_t   expected_grants[$];

    // Predictor state: one free bit per block and the head of the chain that
    // the most recent allocate built.
    logic [bba_pkg::MAP_BLOCKS-1:0] free_blocks;
    logic [bba_pkg::LINK_W-1:0]     head_block;

    // Set at the rising edge at which a request was taken, read by the driver
    // at the following falling edge.
    logic accepted;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int queued_items   = 0;
    int burst_left;
    int gap_left;

    bitmap_block_allocator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .block_addr   (block_addr),
        .free_flag    (free_flag),
        .file_size    (file_size),
        .result_valid (result_valid),
        .block_index  (block_index),
        .chain_next   (chain_next),
        .has_block    (has_block),
        .last         (last),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Reporting and prediction
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic push_grant(input logic [6:0] idx, input logic [7:0] link,
                              input logic has, input logic fin,
                              input bba_pkg::status_t st);
        grant_t g;
        g.block_index = idx;
        g.chain_next  = link;
        g.has_block   = has;
        g.last        = fin;
        g.status      = st;
        expected_grants.push_back(g);
    endtask

    // Applies one accepted request to the mirrored free map and queues the
    // results it must cause, in the order the block is to show them.
    task automatic model_request(input request_t r);
        int need;
        int taken;
        int b;
        if (r.req_type == REQ_LOAD)
        begin
            // Every block number fits the map, so the write always lands.
            free_blocks[r.block_addr] = r.free_flag;
            push_grant(7'd0, bba_pkg::END_OF_CHAIN, 1'b0, 1'b1, bba_pkg::ST_OK);
            return;
        end
        // Each allocate starts a fresh chain.
        head_block = bba_pkg::END_OF_CHAIN;
        if (r.file_size == 16'd0)
        begin
            push_grant(7'd0, bba_pkg::END_OF_CHAIN, 1'b0, 1'b1, bba_pkg::ST_ZERO);
            return;
        end
        need = (int'(r.file_size) + bba_pkg::BLOCK_BYTES - 1) / bba_pkg::BLOCK_BYTES;
        if (need > bba_pkg::MAX_FILE_BLOCKS)
        begin
            push_grant(7'd0, bba_pkg::END_OF_CHAIN, 1'b0, 1'b1, bba_pkg::ST_TOO_MANY);
            return;
        end
        // First-fit scan from block 0; each new block links back to the one
        // taken just before it, so the newest block becomes the chain head.
        taken = 0;
        for (b = 0; b < bba_pkg::MAP_BLOCKS && taken < need; b++)
        begin
            if (free_blocks[b])
            begin
                free_blocks[b] = 1'b0;
                taken++;
                push_grant(b[6:0], head_block, 1'b1, taken == need, bba_pkg::ST_OK);
                head_block = b[7:0];
            end
        end
        // Blocks already taken stay taken; a closing result tells of the
        // shortfall.
        if (taken < need)
        begin
            push_grant(7'd0, bba_pkg::END_OF_CHAIN, 1'b0, 1'b1, bba_pkg::ST_RAN_OUT);
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
        begin
            flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic check_grant();
        grant_t want;
        if (expected_grants.size() == 0)
        begin
            flag_mismatch($sformatf("result with nothing pending: index %0d status %0d",
                                    block_index, status));
            return;
        end
        want = expected_grants.pop_front();
        compare_field("block_index", block_index, want.block_index);
        compare_field("chain_next", chain_next, want.chain_next);
        compare_field("has_block", has_block, want.has_block);
        compare_field("last", last, want.last);
        compare_field("status", status, want.status);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: samples at the rising edge. Results shown in this cycle belong
    // to requests taken earlier, so they are checked before a request taken
    // at this same edge adds its own expectations.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        request_t r;
        if (!rst_n)
        begin
            free_blocks = '0;
            head_block  = bba_pkg::END_OF_CHAIN;
            accepted   <= 1'b0;
        end
        else
        begin
            if (result_valid)
            begin
                check_grant();
            end
            if (start && !busy)
            begin
                r.req_type   = req_type;
                r.block_addr = block_addr;
                r.free_flag  = free_flag;
                r.file_size  = file_size;
                model_request(r);
            end
            accepted <= start && !busy;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: changes inputs at the falling edge. A request stays on the
    // ports until the handshake takes it. The sender works in bursts of
    // random length separated by random gaps; a gap of zero lets bursts run
    // into each other so that long back-to-back stretches also occur.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        request_t nxt;
        logic     drive;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || accepted)
        begin
            drive = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (request_queue.size() > 0)
            begin
                nxt = request_queue.pop_front();
                req_type   <= nxt.req_type;
                block_addr <= nxt.block_addr;
                free_flag  <= nxt.free_flag;
                file_size  <= nxt.file_size;
                drive = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            start <= drive;
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic queue_load(input logic [6:0] addr, input logic flag);
        request_t r;
        r.req_type   = REQ_LOAD;
        r.block_addr = addr;
        r.free_flag  = flag;
        r.file_size  = 16'($urandom);   // ignored by a load
        request_queue.push_back(r);
        queued_items++;
    endtask

    task automatic queue_alloc(input logic [15:0] size);
        request_t r;
        r.req_type   = REQ_ALLOC;
        r.block_addr = 7'($urandom);    // ignored by an allocate
        r.free_flag  = 1'($urandom);
        r.file_size  = size;
        request_queue.push_back(r);
        queued_items++;
    endtask

    // Sizes lean toward files of a few blocks, with zero sizes, oversized
    // files and sizes right up to the block limit mixed in.
    function automatic logic [15:0] pick_file_size();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom_range(32769, 65535));
            2:       return 16'($urandom_range(1, 32768));
            3:       return 16'(bba_pkg::BLOCK_BYTES * $urandom_range(1, 8));
            default: return 16'($urandom_range(1, 4096));
        endcase
    endfunction

    initial
    begin
        int base;
        int target;
        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = REQ_LOAD;
        block_addr = '0;
        free_flag  = 1'b0;
        file_size  = '0;
        burst_left = 1;
        gap_left   = 0;

        // Directed part. The map comes out of reset with no block free.
        queue_alloc(16'd0);          // zero size
        queue_alloc(16'd1);          // empty map: no block, only the shortfall
        queue_load(7'd0, 1'b1);      // lowest block
        queue_load(7'd127, 1'b1);    // highest block
        queue_load(7'd64, 1'b1);
        queue_load(7'd64, 1'b0);     // freed and taken back by a load
        queue_alloc(16'd512);        // exactly one block: block 0
        queue_alloc(16'd1025);       // three blocks wanted, only block 127 left
        queue_alloc(16'd32769);      // one byte over the block limit
        queue_alloc(16'hFFFF);       // largest size the field can carry
        queue_load(7'd3, 1'b1);
        queue_load(7'd5, 1'b1);
        queue_load(7'd6, 1'b1);
        queue_alloc(16'd513);        // two blocks, linked 5 -> 3
        queue_load(7'd42, 1'b1);     // alternating address bit patterns
        queue_load(7'd85, 1'b1);
        queue_alloc(16'd1536);       // three blocks: 6, 42, 85

        // A long run of frees over a random window, then a file of exactly
        // the block limit, so that a full 64-block chain is produced.
        base = $urandom_range(0, bba_pkg::MAP_BLOCKS - 1);
        for (int i = 0; i < 70; i++)
        begin
            queue_load(7'((base + i) % bba_pkg::MAP_BLOCKS), 1'b1);
        end
        queue_alloc(16'd32768);

        // Random part: short runs of loads that mostly free blocks, each run
        // followed by one or two allocates that consume them.
        target = TOTAL_ITEMS;
        while (queued_items < target)
        begin
            repeat ($urandom_range(0, 10))
            begin
                queue_load(7'($urandom), $urandom_range(0, 4) != 0);
            end
            repeat ($urandom_range(1, 2))
            begin
                queue_alloc(pick_file_size());
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every request has gone in and every result has come out.
        while (request_queue.size() != 0 || start || expected_grants.size() != 0)
        begin
            @(posedge clk);
        end
        // Let a full scan pass so that stray results would still be caught.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/bba_pkg.sv
rtl/core/bba_free_map.sv
rtl/core/bitmap_block_allocator.sv
bench/bitmap_block_allocator_tb.sv
